>>> rtl/mlaq_pkg.sv
// mlaq_pkg: shared constants, codes and types of the modem line assembler queue
// used by mlaq_mem, mlaq_ctrl and modem_line_assembler_queue; no dependencies
package mlaq_pkg;

	localparam int QUEUE_LINES_DEF = 8;
	localparam int LINE_BYTES_DEF  = 128;

	localparam logic [7:0] READ_LIMIT_RST = 8'd128;

	localparam logic [7:0] CH_PROMPT = 8'h3E;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_LF     = 8'h0A;

	typedef enum logic [1:0] {
		OP_RECV  = 2'd0,
		OP_READ  = 2'd1,
		OP_CLEAR = 2'd2
	} op_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_READ,
		ST_COPY,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic [7:0] read_char;
		logic       last_char;
		logic       queue_empty;
		logic       line_pushed;
		logic       line_dropped;
		logic [3:0] lines_waiting;
	} res_t;

	// write enables of the three memories
	typedef struct packed {
		logic ls_we;
		logic ln_we;
		logic ab_we;
	} mem_we_t;

endpackage

>>> rtl/mlaq_mem.sv
// mlaq_mem: line store, line length table and assembly buffer
// synchronous memories, one write and one registered read port each; uses mlaq_pkg
module mlaq_mem #(
	parameter int QUEUE_LINES = mlaq_pkg::QUEUE_LINES_DEF,
	parameter int LINE_BYTES  = mlaq_pkg::LINE_BYTES_DEF
) (
	input  logic                                       clk,
	input  mlaq_pkg::mem_we_t                          we,
	input  logic [$clog2(QUEUE_LINES*LINE_BYTES)-1:0] ls_waddr,
	input  logic [7:0]                                 ls_wdata,
	input  logic [$clog2(QUEUE_LINES*LINE_BYTES)-1:0] ls_raddr,
	output logic [7:0]                                 ls_rdata,
	input  logic [$clog2(QUEUE_LINES)-1:0]             ln_waddr,
	input  logic [$clog2(LINE_BYTES)-1:0]              ln_wdata,
	input  logic [$clog2(QUEUE_LINES)-1:0]             ln_raddr,
	output logic [$clog2(LINE_BYTES)-1:0]              ln_rdata,
	input  logic [$clog2(LINE_BYTES)-1:0]              ab_waddr,
	input  logic [7:0]                                 ab_wdata,
	input  logic [$clog2(LINE_BYTES)-1:0]              ab_raddr,
	output logic [7:0]                                 ab_rdata
);

	localparam int LEN_W = $clog2(LINE_BYTES);

	logic [7:0]       line_store [QUEUE_LINES*LINE_BYTES];
	logic [LEN_W-1:0] line_len   [QUEUE_LINES];
	logic [7:0]       asm_buf    [LINE_BYTES];

	always_ff @(posedge clk) begin
		if (we.ls_we) begin
			line_store[ls_waddr] <= ls_wdata;
		end
		ls_rdata <= line_store[ls_raddr];
	end

	always_ff @(posedge clk) begin
		if (we.ln_we) begin
			line_len[ln_waddr] <= ln_wdata;
		end
		ln_rdata <= line_len[ln_raddr];
	end

	always_ff @(posedge clk) begin
		if (we.ab_we) begin
			asm_buf[ab_waddr] <= ab_wdata;
		end
		ab_rdata <= asm_buf[ab_raddr];
	end

endmodule

>>> rtl/mlaq_ctrl.sv
// mlaq_ctrl: sequencer for byte assembly, line copy, character read and clear
// drives the memories of mlaq_mem; uses mlaq_pkg
module mlaq_ctrl #(
	parameter int QUEUE_LINES = mlaq_pkg::QUEUE_LINES_DEF,
	parameter int LINE_BYTES  = mlaq_pkg::LINE_BYTES_DEF
) (
	input  logic                                       clk,
	input  logic                                       arst_n,
	input  logic [7:0]                                 read_limit,
	input  logic                                       in_valid,
	output logic                                       in_ready,
	input  logic [1:0]                                 opcode,
	input  logic [7:0]                                 byte_in,
	output logic                                       res_valid,
	input  logic                                       res_take,
	output mlaq_pkg::res_t                             res,
	output mlaq_pkg::mem_we_t                          we,
	output logic [$clog2(QUEUE_LINES*LINE_BYTES)-1:0] ls_waddr,
	output logic [7:0]                                 ls_wdata,
	output logic [$clog2(QUEUE_LINES*LINE_BYTES)-1:0] ls_raddr,
	input  logic [7:0]                                 ls_rdata,
	output logic [$clog2(QUEUE_LINES)-1:0]             ln_waddr,
	output logic [$clog2(LINE_BYTES)-1:0]              ln_wdata,
	output logic [$clog2(QUEUE_LINES)-1:0]             ln_raddr,
	input  logic [$clog2(LINE_BYTES)-1:0]              ln_rdata,
	output logic [$clog2(LINE_BYTES)-1:0]              ab_waddr,
	output logic [7:0]                                 ab_wdata,
	output logic [$clog2(LINE_BYTES)-1:0]              ab_raddr,
	input  logic [7:0]                                 ab_rdata
);

	localparam int ADDR_W = $clog2(QUEUE_LINES*LINE_BYTES);
	localparam int LEN_W  = $clog2(LINE_BYTES);
	localparam int SLOT_W = $clog2(QUEUE_LINES);
	localparam int CNT_W  = $clog2(QUEUE_LINES+1);
	localparam int CW     = ((LEN_W > 8) ? LEN_W : 8) + 1;

	localparam logic [ADDR_W-1:0] ROW      = ADDR_W'(LINE_BYTES);
	localparam logic [LEN_W-1:0]  IDX_FULL = LEN_W'(LINE_BYTES-1);
	localparam logic [SLOT_W-1:0] SLOT_TOP = SLOT_W'(QUEUE_LINES-1);
	localparam logic [CNT_W-1:0]  CNT_MAX  = CNT_W'(QUEUE_LINES);

	mlaq_pkg::state_t state_q, state_d;

	logic [LEN_W-1:0]  asm_idx_q, asm_idx_d;
	logic [SLOT_W-1:0] wr_slot_q, wr_slot_d;
	logic [SLOT_W-1:0] rd_slot_q, rd_slot_d;
	logic [CNT_W-1:0]  cnt_q, cnt_d;
	logic [LEN_W-1:0]  rd_pos_q, rd_pos_d;
	logic [LEN_W-1:0]  cp_q, cp_d;
	logic              cp_v_s1;
	logic [LEN_W-1:0]  cp_a_s1;
	mlaq_pkg::res_t    res_q, res_d;

	logic              room;
	logic              is_prompt;
	logic              is_term;
	logic              queue_asm;
	logic [7:0]        lim;
	logic [CW-1:0]     len_c, lim_c, pos_c, tlen;
	logic              fin;
	logic [SLOT_W-1:0] wr_slot_nx, rd_slot_nx;

	assign room       = (cnt_q < CNT_MAX);
	assign is_prompt  = (byte_in == mlaq_pkg::CH_PROMPT) && (asm_idx_q == '0);
	assign is_term    = (byte_in == mlaq_pkg::CH_CR) || (byte_in == mlaq_pkg::CH_LF);
	// terminator on a non-empty line, or a plain byte on a full line
	assign queue_asm  = is_term ? (asm_idx_q != '0) : (!is_prompt && asm_idx_q == IDX_FULL);
	assign wr_slot_nx = (wr_slot_q == SLOT_TOP) ? '0 : wr_slot_q + 1'b1;
	assign rd_slot_nx = (rd_slot_q == SLOT_TOP) ? '0 : rd_slot_q + 1'b1;

	// characters to return for the oldest line
	assign lim   = (read_limit == 8'd0) ? 8'd0 : read_limit - 8'd1;
	assign len_c = CW'(ln_rdata);
	assign lim_c = CW'(lim);
	assign pos_c = CW'(rd_pos_q);
	assign tlen  = (len_c < lim_c) ? len_c : lim_c;

	always_comb begin
		state_d   = state_q;
		asm_idx_d = asm_idx_q;
		wr_slot_d = wr_slot_q;
		rd_slot_d = rd_slot_q;
		cnt_d     = cnt_q;
		rd_pos_d  = rd_pos_q;
		cp_d      = cp_q;
		res_d     = res_q;
		in_ready  = 1'b0;
		res_valid = 1'b0;
		fin       = 1'b0;

		we.ls_we  = cp_v_s1;
		we.ln_we  = 1'b0;
		we.ab_we  = 1'b0;
		ls_raddr  = rd_slot_q * ROW + ADDR_W'(rd_pos_q);
		ls_waddr  = wr_slot_q * ROW + (cp_v_s1 ? ADDR_W'(cp_a_s1) : '0);
		ls_wdata  = cp_v_s1 ? ab_rdata : mlaq_pkg::CH_PROMPT;
		ln_raddr  = rd_slot_q;
		ln_waddr  = wr_slot_q;
		ln_wdata  = asm_idx_q;
		ab_raddr  = cp_q;
		ab_waddr  = asm_idx_q;
		ab_wdata  = byte_in;

		case (state_q)
			mlaq_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					res_d   = '0;
					state_d = mlaq_pkg::ST_EMIT;
					case (opcode)
						mlaq_pkg::OP_RECV: begin
							if (is_prompt) begin
								if (room) begin
									we.ls_we          = 1'b1;
									we.ln_we          = 1'b1;
									ln_wdata          = LEN_W'(1);
									wr_slot_d         = wr_slot_nx;
									cnt_d             = cnt_q + 1'b1;
									res_d.line_pushed = 1'b1;
								end else begin
									res_d.line_dropped = 1'b1;
								end
							end else if (queue_asm) begin
								if (room) begin
									cp_d    = '0;
									state_d = mlaq_pkg::ST_COPY;
								end else begin
									res_d.line_dropped = 1'b1;
									asm_idx_d          = '0;
								end
							end else if (!is_term) begin
								we.ab_we  = 1'b1;
								asm_idx_d = asm_idx_q + 1'b1;
							end
						end
						mlaq_pkg::OP_READ: begin
							if (cnt_q == '0) begin
								res_d.queue_empty = 1'b1;
							end else begin
								state_d = mlaq_pkg::ST_READ;
							end
						end
						mlaq_pkg::OP_CLEAR: begin
							wr_slot_d = '0;
							rd_slot_d = '0;
							cnt_d     = '0;
							rd_pos_d  = '0;
							asm_idx_d = '0;
						end
						default: begin
						end
					endcase
				end
			end
			mlaq_pkg::ST_READ: begin
				if (pos_c >= tlen) begin
					fin = 1'b1;
				end else begin
					res_d.read_char = ls_rdata;
					fin             = ((pos_c + 1'b1) >= tlen);
					rd_pos_d        = rd_pos_q + 1'b1;
				end
				if (fin) begin
					res_d.last_char = 1'b1;
					rd_pos_d        = '0;
					rd_slot_d       = rd_slot_nx;
					cnt_d           = cnt_q - 1'b1;
				end
				state_d = mlaq_pkg::ST_EMIT;
			end
			mlaq_pkg::ST_COPY: begin
				// read issued here, store write in the following cycle from the s1 stage
				if (cp_q != asm_idx_q) begin
					cp_d = cp_q + 1'b1;
				end else begin
					we.ln_we          = 1'b1;
					wr_slot_d         = wr_slot_nx;
					cnt_d             = cnt_q + 1'b1;
					asm_idx_d         = '0;
					res_d.line_pushed = 1'b1;
					state_d           = mlaq_pkg::ST_EMIT;
				end
			end
			mlaq_pkg::ST_EMIT: begin
				res_valid = 1'b1;
				if (res_take) begin
					state_d = mlaq_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = mlaq_pkg::ST_IDLE;
			end
		endcase
	end

	always_comb begin
		res               = res_q;
		res.lines_waiting = 4'(cnt_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= mlaq_pkg::ST_IDLE;
			asm_idx_q <= '0;
			wr_slot_q <= '0;
			rd_slot_q <= '0;
			cnt_q     <= '0;
			rd_pos_q  <= '0;
			cp_q      <= '0;
			cp_v_s1   <= 1'b0;
		end else begin
			state_q   <= state_d;
			asm_idx_q <= asm_idx_d;
			wr_slot_q <= wr_slot_d;
			rd_slot_q <= rd_slot_d;
			cnt_q     <= cnt_d;
			rd_pos_q  <= rd_pos_d;
			cp_q      <= cp_d;
			cp_v_s1   <= (state_q == mlaq_pkg::ST_COPY) && (cp_q != asm_idx_q);
		end
	end

	always_ff @(posedge clk) begin
		res_q   <= res_d;
		cp_a_s1 <= cp_q;
	end

`ifndef SYNTH
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_MAX)
		else $error("queued line count above queue depth");

	a_asm_bound: assert property (@(posedge clk) disable iff (!arst_n)
		asm_idx_q <= IDX_FULL)
		else $error("assembly index past line size");

	a_copy_room: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == mlaq_pkg::ST_COPY |-> cnt_q < CNT_MAX)
		else $error("line copy started into a full queue");

	a_empty_slots: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q == '0 |-> wr_slot_q == rd_slot_q)
		else $error("empty queue with split slot pointers");

	a_copy_drain: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == mlaq_pkg::ST_COPY && cp_q == asm_idx_q |=> !cp_v_s1)
		else $error("store write pending after line copy finished");
`endif

endmodule

>>> rtl/modem_line_assembler_queue.sv
// modem_line_assembler_queue: top level, config register and result register
// instantiates mlaq_mem and mlaq_ctrl; uses mlaq_pkg
//
//   channel  direction  handshake            payload
//   in       input      in_valid/in_ready    opcode, byte_in
//   out      output     out_valid/out_ready  read_char .. lines_waiting
//   cfg      input      cfg_we               cfg_wdata (read_limit)
//
// a received byte, a clear or a read of an empty queue passes the idle and emit states,
// a read of a queued line also the read state (registered memory read)
// a byte that queues an assembled line of n characters passes the copy state: the copy loop moves
// one character a cycle through the assembly buffer read port into the line store
// one result register sits on the output; the next beat is taken while it waits
// asynchronous reset clears control state only; memories need no clearing pass
module modem_line_assembler_queue #(
	parameter int QUEUE_LINES = mlaq_pkg::QUEUE_LINES_DEF,
	parameter int LINE_BYTES  = mlaq_pkg::LINE_BYTES_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [7:0] cfg_wdata,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [1:0] opcode,
	input  logic [7:0] byte_in,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] read_char,
	output logic       last_char,
	output logic       queue_empty,
	output logic       line_pushed,
	output logic       line_dropped,
	output logic [3:0] lines_waiting
);

	localparam int ADDR_W = $clog2(QUEUE_LINES*LINE_BYTES);
	localparam int LEN_W  = $clog2(LINE_BYTES);
	localparam int SLOT_W = $clog2(QUEUE_LINES);

	logic [7:0]        read_limit_q;
	logic              out_valid_q;
	mlaq_pkg::res_t    out_q;
	logic              res_valid;
	logic              res_take;
	mlaq_pkg::res_t    res;
	mlaq_pkg::mem_we_t we;

	logic [ADDR_W-1:0] ls_waddr, ls_raddr;
	logic [7:0]        ls_wdata, ls_rdata;
	logic [SLOT_W-1:0] ln_waddr, ln_raddr;
	logic [LEN_W-1:0]  ln_wdata, ln_rdata;
	logic [LEN_W-1:0]  ab_waddr, ab_raddr;
	logic [7:0]        ab_wdata, ab_rdata;

	mlaq_mem #(
		.QUEUE_LINES(QUEUE_LINES),
		.LINE_BYTES (LINE_BYTES)
	) u_mem (
		.clk     (clk),
		.we      (we),
		.ls_waddr(ls_waddr),
		.ls_wdata(ls_wdata),
		.ls_raddr(ls_raddr),
		.ls_rdata(ls_rdata),
		.ln_waddr(ln_waddr),
		.ln_wdata(ln_wdata),
		.ln_raddr(ln_raddr),
		.ln_rdata(ln_rdata),
		.ab_waddr(ab_waddr),
		.ab_wdata(ab_wdata),
		.ab_raddr(ab_raddr),
		.ab_rdata(ab_rdata)
	);

	mlaq_ctrl #(
		.QUEUE_LINES(QUEUE_LINES),
		.LINE_BYTES (LINE_BYTES)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.read_limit(read_limit_q),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.opcode    (opcode),
		.byte_in   (byte_in),
		.res_valid (res_valid),
		.res_take  (res_take),
		.res       (res),
		.we        (we),
		.ls_waddr  (ls_waddr),
		.ls_wdata  (ls_wdata),
		.ls_raddr  (ls_raddr),
		.ls_rdata  (ls_rdata),
		.ln_waddr  (ln_waddr),
		.ln_wdata  (ln_wdata),
		.ln_raddr  (ln_raddr),
		.ln_rdata  (ln_rdata),
		.ab_waddr  (ab_waddr),
		.ab_wdata  (ab_wdata),
		.ab_raddr  (ab_raddr),
		.ab_rdata  (ab_rdata)
	);

	// result register loads when empty or being drained this cycle
	assign res_take = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			read_limit_q <= mlaq_pkg::READ_LIMIT_RST;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg_we) begin
				read_limit_q <= cfg_wdata;
			end
			if (res_take) begin
				out_valid_q <= res_valid;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (res_take && res_valid) begin
			out_q <= res;
		end
	end

	assign out_valid     = out_valid_q;
	assign read_char     = out_q.read_char;
	assign last_char     = out_q.last_char;
	assign queue_empty   = out_q.queue_empty;
	assign line_pushed   = out_q.line_pushed;
	assign line_dropped  = out_q.line_dropped;
	assign lines_waiting = out_q.lines_waiting;

endmodule
